FILE: rtl/dipd_pkg.sv
// Shared types and constants for the icon bitmap body decoder.
`default_nettype none
package dipd_pkg;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_BITS_PER_PIXEL = 3'd2;
	localparam logic [2:0] REG_COLOR_COUNT    = 3'd3;
	localparam logic [2:0] REG_BOTTOM_UP      = 3'd4;

	typedef enum logic [1:0] {
		KIND_PIXEL = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_DONE  = 2'd2,
		KIND_TRUNC = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_PALETTE = 2'd0,
		PH_IMAGE   = 2'd1,
		PH_MASK    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CMD_INDEXED = 2'd0,
		CMD_MASK    = 2'd1,
		CMD_DIRECT  = 2'd2
	} cmd_mode_t;

	typedef enum logic [1:0] {
		PW_1 = 2'd0,
		PW_4 = 2'd1,
		PW_8 = 2'd2
	} pix_w_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} in_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [31:0] argb;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [8:0] image_width;
		logic [8:0] image_height;
		logic [5:0] bits_per_pixel;
		logic [8:0] color_count;
		logic       bottom_up;
	} cfg_t;

	// one accepted byte's work for the back end
	typedef struct packed {
		cmd_mode_t   mode;
		pix_w_t      pix_w;
		logic [7:0]  data;
		logic [7:0]  col0;
		logic [7:0]  row;
		logic [31:0] argb;
		logic [7:0]  slots;
		logic        done;
		logic        trunc;
	} cmd_t;

	typedef struct packed {
		logic        en;
		logic        clr;
		logic [7:0]  addr;
		logic [31:0] data;
	} pal_wr_t;

endpackage
`default_nettype wire

FILE: rtl/dipd_fifo.sv
// Small command queue between the byte parser and the result generator.
`default_nettype none
module dipd_fifo import dipd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_data,
	output logic      full,
	input  wire logic pop,
	output cmd_t      pop_data,
	output logic      empty
);
	cmd_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q, rp_q;
	logic [Q_AW:0]   cnt_q;

	assign full     = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/dipd_front.sv
// Byte parser: tracks the body parts, loads the palette and queues per-byte work.
`default_nettype none
module dipd_front import dipd_pkg::*; #(
	parameter int MAX_DIM       = 256,
	parameter int PALETTE_DEPTH = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  in_t       in_data,
	input  cfg_t      cfg,
	input  wire logic back_idle,
	input  wire logic q_full,
	output logic      push,
	output cmd_t      cmd,
	output pal_wr_t   pal_wr
);
	phase_t      phase_q, phase_d, ph_a, ph_b;
	logic [8:0]  entry_q, entry_d;
	logic [8:0]  rowc_q, rowc_d;
	logic [10:0] bir_q, bir_d;
	logic [9:0]  pc_q, pc_d;
	logic [23:0] gat_q, gat_d;
	logic [1:0]  big_q, big_d;
	logic        clr_pend_q;

	logic [8:0]  w, h, cc;
	logic        depth_ok, acc, done, trunc, img;
	logic [5:0]  pb;
	logic [14:0] wpb;
	logic [11:0] stride;
	logic [8:0]  rowo;
	logic [3:0]  npos;
	logic [9:0]  pc_lim;
	logic [7:0]  byte_v;
	logic [7:0]  slots;
	logic [2:0]  nbytes;

	always_comb begin
		w = cfg.image_width;
		if (w == '0) w = 9'd1;
		else if ({4'd0, w} > 13'(MAX_DIM)) w = 9'(MAX_DIM);
		h = cfg.image_height;
		if (h == '0) h = 9'd1;
		else if ({4'd0, h} > 13'(MAX_DIM)) h = 9'(MAX_DIM);
		cc = ({1'b0, cfg.color_count} > 10'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH)
			: cfg.color_count;
	end

	assign depth_ok = (cfg.bits_per_pixel == 6'd1) || (cfg.bits_per_pixel == 6'd4) ||
		(cfg.bits_per_pixel == 6'd8) || (cfg.bits_per_pixel == 6'd16) ||
		(cfg.bits_per_pixel == 6'd24) || (cfg.bits_per_pixel == 6'd32);

	always_comb begin
		ph_a = phase_q;
		if (phase_q == PH_PALETTE && entry_q >= cc) ph_a = PH_IMAGE;
		ph_b = ph_a;
		if (ph_a == PH_IMAGE && !depth_ok) ph_b = PH_MASK;
	end

	// palette is only touched while the back end has nothing in flight
	assign in_ready = !q_full && !((clr_pend_q || ph_b == PH_PALETTE) && !back_idle);
	assign acc      = in_valid && in_ready;
	assign byte_v   = in_data.data_byte;
	assign img      = (ph_b == PH_IMAGE);
	assign pb       = img ? cfg.bits_per_pixel : 6'd1;

	always_comb begin
		unique case (pb)
			6'd4:    wpb = {4'd0, w, 2'd0};
			6'd8:    wpb = {3'd0, w, 3'd0};
			6'd16:   wpb = {2'd0, w, 4'd0};
			6'd24:   wpb = {2'd0, w, 4'd0} + {3'd0, w, 3'd0};
			6'd32:   wpb = {1'b0, w, 5'd0};
			default: wpb = {6'd0, w};
		endcase
		stride = {(wpb[14:5] + 10'(wpb[4:0] != 5'd0)), 2'd0};
		rowo   = cfg.bottom_up ? (h - 9'd1 - rowc_q) : rowc_q;
		unique case (pb)
			6'd4:    npos = 4'd2;
			6'd8:    npos = 4'd1;
			default: npos = 4'd8;
		endcase
		unique case (pb)
			6'd16:   nbytes = 3'd2;
			6'd24:   nbytes = 3'd3;
			default: nbytes = 3'd4;
		endcase
		for (int j = 0; j < 8; j++) begin
			slots[j] = (4'(j) < npos) && ((pc_q + 10'(j)) < {1'b0, w}) &&
				(img || byte_v[7-j]);
		end
		pc_lim = pc_q + {6'd0, npos};
		if (pc_lim > {1'b0, w}) pc_lim = {1'b0, w};
	end

	always_comb begin
		phase_d = ph_b;
		entry_d = entry_q;
		rowc_d  = rowc_q;
		bir_d   = bir_q;
		pc_d    = pc_q;
		gat_d   = gat_q;
		big_d   = big_q;
		done    = 1'b0;
		pal_wr  = '0;
		cmd     = '0;
		cmd.row  = rowo[7:0];
		cmd.col0 = pc_q[7:0];
		cmd.data = byte_v;
		cmd.mode = img ? CMD_INDEXED : CMD_MASK;
		unique case (pb)
			6'd4:    cmd.pix_w = PW_4;
			6'd8:    cmd.pix_w = PW_8;
			default: cmd.pix_w = PW_1;
		endcase
		pal_wr.clr = acc && clr_pend_q;
		if (ph_b == PH_PALETTE) begin
			if (big_q != 2'd3) begin
				unique case (big_q)
					2'd0:    gat_d[7:0]   = gat_q[7:0] | byte_v;
					2'd1:    gat_d[15:8]  = gat_q[15:8] | byte_v;
					default: gat_d[23:16] = gat_q[23:16] | byte_v;
				endcase
				big_d = big_q + 2'd1;
			end else begin
				pal_wr.en   = acc && ({1'b0, entry_q} < 10'(PALETTE_DEPTH));
				pal_wr.addr = entry_q[7:0];
				pal_wr.data = {8'hFF, gat_q};
				entry_d = entry_q + 9'd1;
				gat_d   = '0;
				big_d   = '0;
			end
		end else begin
			if (pb <= 6'd8) begin
				cmd.slots = slots;
				if (pc_q < {1'b0, w}) pc_d = pc_lim;
			end else if (pc_q < {1'b0, w}) begin
				if ({1'b0, big_q} + 3'd1 < nbytes) begin
					unique case (big_q)
						2'd0:    gat_d[7:0]   = gat_q[7:0] | byte_v;
						2'd1:    gat_d[15:8]  = gat_q[15:8] | byte_v;
						default: gat_d[23:16] = gat_q[23:16] | byte_v;
					endcase
					big_d = big_q + 2'd1;
				end else begin
					cmd.mode     = CMD_DIRECT;
					cmd.slots[0] = 1'b1;
					unique case (pb)
						6'd16: cmd.argb = {8'hFF, byte_v[6:2], 3'd0,
							byte_v[1:0], gat_q[7:5], 3'd0, gat_q[4:0], 3'd0};
						6'd24: cmd.argb = {8'hFF, byte_v, gat_q[15:0]};
						default: cmd.argb = {byte_v, gat_q};
					endcase
					pc_d  = pc_q + 10'd1;
					gat_d = '0;
					big_d = '0;
				end
			end
			bir_d = bir_q + 11'd1;
			if ({1'b0, bir_d} >= stride) begin
				bir_d  = '0;
				pc_d   = '0;
				gat_d  = '0;
				big_d  = '0;
				rowc_d = rowc_q + 9'd1;
				if (rowc_d >= h) begin
					rowc_d = '0;
					if (img) phase_d = PH_MASK;
					else done = 1'b1;
				end
			end
		end
		trunc     = in_data.end_of_data && !done;
		cmd.done  = done;
		cmd.trunc = trunc;
		if (done || trunc) begin
			phase_d = PH_PALETTE;
			entry_d = '0;
			rowc_d  = '0;
			bir_d   = '0;
			pc_d    = '0;
			gat_d   = '0;
			big_d   = '0;
		end
		push = acc && ((|cmd.slots) || done || trunc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_PALETTE;
			entry_q    <= '0;
			rowc_q     <= '0;
			bir_q      <= '0;
			pc_q       <= '0;
			gat_q      <= '0;
			big_q      <= '0;
			clr_pend_q <= 1'b0;
		end else if (acc) begin
			phase_q    <= phase_d;
			entry_q    <= entry_d;
			rowc_q     <= rowc_d;
			bir_q      <= bir_d;
			pc_q       <= pc_d;
			gat_q      <= gat_d;
			big_q      <= big_d;
			clr_pend_q <= done || trunc;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/dipd_back.sv
// Result generator: expands queued bytes via palette; one result per cycle unless stalled.
`default_nettype none
module dipd_back import dipd_pkg::*; #(
	parameter int PALETTE_DEPTH = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  cmd_t      q_data,
	output logic      q_pop,
	input  pal_wr_t   pal_wr,
	output logic      back_idle,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);
	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	logic [31:0]              pal_mem [PALETTE_DEPTH];
	logic [PALETTE_DEPTH-1:0] pv_q;

	cmd_t       cur_q;
	logic       cur_v_q;
	logic [9:0] rem_q;

	logic       adv, emit, last, rd_en, oob;
	logic [9:0] sel, rem_left;
	logic [2:0] j;
	logic [7:0] idx;
	kind_t      kind;
	logic [7:0] col, row;
	logic [31:0] argb;

	logic        s1_v_s1, pal_s1, oob_s1, last_s1;
	kind_t       kind_s1;
	logic [7:0]  col_s1, row_s1, idx_s1;
	logic [31:0] argb_s1, rd_s1;
	logic        rdv_s1;

	assign adv      = !s1_v_s1 || out_ready;
	assign emit     = cur_v_q && adv;
	assign sel      = rem_q & (~rem_q + 10'd1);
	assign rem_left = rem_q & ~sel;
	assign last     = (rem_left == '0);
	assign q_pop    = !q_empty && (!cur_v_q || (emit && last));
	assign back_idle = !cur_v_q && q_empty;

	always_comb begin
		j = '0;
		for (int i = 0; i < 8; i++) begin
			if (sel[i]) j = 3'(i);
		end
		unique case (cur_q.pix_w)
			PW_4:    idx = (j == 3'd0) ? {4'd0, cur_q.data[7:4]} : {4'd0, cur_q.data[3:0]};
			PW_8:    idx = cur_q.data;
			default: idx = {7'd0, cur_q.data[3'd7 - j]};
		endcase
		oob  = ({1'b0, idx} >= 9'(PALETTE_DEPTH));
		col  = cur_q.col0 + {5'd0, j};
		row  = cur_q.row;
		argb = '0;
		priority if (sel[9]) begin
			kind = KIND_TRUNC;
			col  = '0;
			row  = '0;
		end else if (sel[8]) begin
			kind = KIND_DONE;
			col  = '0;
			row  = '0;
		end else if (cur_q.mode == CMD_MASK) begin
			kind = KIND_CLEAR;
		end else begin
			kind = KIND_PIXEL;
			argb = cur_q.argb;
		end
		rd_en = emit && (sel[9:8] == 2'b00) && (cur_q.mode == CMD_INDEXED);
	end

	always_ff @(posedge clk) begin
		if (pal_wr.en) pal_mem[pal_wr.addr[AW-1:0]] <= pal_wr.data;
		if (rd_en) begin
			rd_s1  <= pal_mem[idx[AW-1:0]];
			rdv_s1 <= pv_q[idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= '0;
		end else begin
			if (pal_wr.clr) pv_q <= '0;
			if (pal_wr.en) pv_q[pal_wr.addr[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			rem_q   <= '0;
		end else if (q_pop) begin
			cur_v_q <= 1'b1;
			rem_q   <= {q_data.trunc, q_data.done, q_data.slots};
		end else if (emit) begin
			rem_q <= rem_left;
			if (last) cur_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s1_v_s1 <= 1'b0;
		else if (adv) s1_v_s1 <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_s1 <= kind;
			col_s1  <= col;
			row_s1  <= row;
			argb_s1 <= argb;
			pal_s1  <= rd_en;
			oob_s1  <= oob;
			idx_s1  <= idx;
			last_s1 <= last;
		end
	end

	// entries not loaded since image start: index 0 reads black, index 1 white, others zero
	always_comb begin
		out_valid     = s1_v_s1;
		out_data.kind = kind_s1;
		out_data.col  = col_s1;
		out_data.row  = row_s1;
		out_data.last = last_s1;
		if (!pal_s1) out_data.argb = argb_s1;
		else if (oob_s1) out_data.argb = '0;
		else if (rdv_s1) out_data.argb = rd_s1;
		else if (idx_s1 == 8'd0) out_data.argb = 32'hFF00_0000;
		else if (idx_s1 == 8'd1) out_data.argb = 32'hFFFF_FFFF;
		else out_data.argb = '0;
	end
endmodule
`default_nettype wire

FILE: rtl/dib_icon_pixel_decoder.sv
// Top level: icon bitmap body decoder, byte parser, command queue and result generator.
// Results leave at one per cycle while work is queued and out_ready is high.
// Throughput: one byte per cycle, limited by result count (up to nine per byte) at the output.
// Palette bytes and the first byte of a new image wait until all queued work has drained.
// Reset: asynchronous; registers get defaults; palette index 0 reads black, 1 white, others 0.
`default_nettype none
module dib_icon_pixel_decoder import dipd_pkg::*; #(
	parameter int MAX_DIM       = 256,
	parameter int PALETTE_DEPTH = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  in_t             in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_t            out_data,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [8:0] cfg_data
);
	cfg_t    cfg_q;
	logic    back_idle, q_full, q_empty, push, q_pop;
	cmd_t    cmd, q_data;
	pal_wr_t pal_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width    <= 9'd16;
			cfg_q.image_height   <= 9'd16;
			cfg_q.bits_per_pixel <= 6'd8;
			cfg_q.color_count    <= 9'd0;
			cfg_q.bottom_up      <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_data;
				REG_IMAGE_HEIGHT:   cfg_q.image_height   <= cfg_data;
				REG_BITS_PER_PIXEL: cfg_q.bits_per_pixel <= cfg_data[5:0];
				REG_COLOR_COUNT:    cfg_q.color_count    <= cfg_data;
				REG_BOTTOM_UP:      cfg_q.bottom_up      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	dipd_front #(.MAX_DIM(MAX_DIM), .PALETTE_DEPTH(PALETTE_DEPTH)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .cfg(cfg_q),
		.back_idle, .q_full, .push, .cmd, .pal_wr
	);

	dipd_fifo u_fifo (
		.clk, .arst_n, .push, .push_data(cmd), .full(q_full),
		.pop(q_pop), .pop_data(q_data), .empty(q_empty)
	);

	dipd_back #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_back (
		.clk, .arst_n, .q_empty, .q_data, .q_pop, .pal_wr, .back_idle,
		.out_valid, .out_ready, .out_data
	);

	a_pal_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pal_wr.en || pal_wr.clr) |-> back_idle)
		else $error("palette changed with work in flight");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("command queue overflow");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.kind == KIND_DONE || out_data.kind == KIND_TRUNC))
		|-> out_data.last)
		else $error("image end result not last");
endmodule
`default_nettype wire
